[sv/nam_pkg.sv]
// shared constants, codes and helpers for the nibble allocation map engine
// no dependencies; imported by the engine top level
`timescale 1ns / 1ps
`default_nettype none
package nam_pkg;

    localparam int MAP_ENTRIES = 1024;
    localparam int IW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    // position width: covers a 16-bit index plus the largest size
    localparam int PW = 17;

    typedef logic [PW-1:0] pos_t;
    typedef logic [3:0]    entry_t;

    // request codes
    localparam logic [2:0] F_CLAIM  = 3'd0;
    localparam logic [2:0] F_FREE   = 3'd1;
    localparam logic [2:0] F_FORCE  = 3'd2;
    localparam logic [2:0] F_LENGTH = 3'd3;
    localparam logic [2:0] F_RESIZE = 3'd4;
    localparam logic [2:0] F_RDOPEN = 3'd5;
    localparam logic [2:0] F_WROPEN = 3'd6;
    localparam logic [2:0] F_CLOSE  = 3'd7;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_OWNER = 3'd1;
    localparam logic [2:0] ST_NOT_SHRD  = 3'd2;
    localparam logic [2:0] ST_BUSY      = 3'd3;
    localparam logic [2:0] ST_NO_ROOM   = 3'd4;
    localparam logic [2:0] ST_FREE      = 3'd5;

    // map entry codes
    localparam entry_t E_FREE     = 4'd0;
    localparam entry_t E_PROC_MAX = 4'd7;
    localparam entry_t E_SHARED   = 4'd8;
    localparam entry_t E_WLOCK    = 4'd9;
    localparam entry_t E_RLOCK1   = 4'd10;
    localparam entry_t E_RLOCK5   = 4'd14;
    localparam entry_t E_CONT     = 4'hF;

    localparam logic [10:0] LEN_MAX = 11'd2047;

    function automatic logic [10:0] sat_len(input pos_t n);
        return (n > pos_t'(LEN_MAX)) ? LEN_MAX : n[10:0];
    endfunction

endpackage
`default_nettype wire

[sv/nibble_allocation_map_engine.sv]
// Nibble allocation map engine: one 4-bit owner code per heap byte, held in a
// single-port synchronous map memory of MAP_ENTRIES entries (1024) with a registered
// read. After reset a clearing pass writes every entry to free, one per cycle; no
// request is taken until it ends, while heap base address writes are taken at any
// time. Each request gives exactly one result. A request walks the map one entry at a
// time (read, then decide) back to the chunk base, then, except for shared open and
// close, forward over the chunk (for claim, over the requested range) and, for resize,
// over the free gap to the right and left as needed; writes run one entry per cycle.
// Depends on nam_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nibble_allocation_map_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,    // heap base address
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // addr[15:0], size[26:16], pid[30:27], zero
    input  wire logic [2:0]  s_tuser,     // func[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,     // result_addr[15:0], chunk_length[26:16],
                                          // move_needed[27], move_from[43:28],
                                          // move_length[54:44], zero
    output logic [2:0]       m_tuser      // status[2:0]
);
    import nam_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WALKB = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_FWD   = 4'd5;
    localparam logic [3:0] S_RWALK = 4'd6;
    localparam logic [3:0] S_LWALK = 4'd7;
    localparam logic [3:0] S_FILL  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    entry_t map_mem [MAP_ENTRIES];
    entry_t rdata_reg;

    logic [3:0]  state_reg, state_next;
    logic        ph_reg, ph_next;
    logic        first_reg, first_next;
    pos_t        pos_reg, pos_next;
    logic [15:0] heap_base_reg;

    logic [2:0]  func_reg, func_next;
    logic [15:0] idx_reg, idx_next;
    logic [10:0] size_reg, size_next;
    logic [3:0]  pid_reg, pid_next;
    pos_t        base_reg, base_next;
    entry_t      e_reg, e_next;
    entry_t      eidx_reg, eidx_next;
    pos_t        end_reg, end_next;
    pos_t        rb_reg, rb_next;
    pos_t        lb_reg, lb_next;
    pos_t        fs_reg, fs_next;
    pos_t        fe_reg, fe_next;
    pos_t        ft_reg, ft_next;
    entry_t      fv_reg, fv_next;
    entry_t      rv_reg, rv_next;

    logic [2:0]  st_reg, st_next;
    logic [15:0] raddr_reg, raddr_next;
    logic [10:0] clen_reg, clen_next;
    logic        mv_reg, mv_next;
    logic [15:0] mfrom_reg, mfrom_next;
    logic [10:0] mlen_reg, mlen_next;

    logic        m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg, m_data_next;
    logic [2:0]  m_user_reg, m_user_next;

    logic        we;
    entry_t      wdata;
    entry_t      ev;
    logic        in_range;
    pos_t        bs;
    pos_t        lb_dec;
    logic        do_dec;
    logic [15:0] s_addr;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign in_range = (pos_reg < pos_t'(MAP_ENTRIES));
    assign ev       = in_range ? rdata_reg : E_FREE;
    assign bs       = base_reg + pos_t'(size_reg);
    assign s_addr   = s_tdata[15:0];

    always_ff @(posedge aclk) begin
        if (we) begin
            map_mem[pos_reg[IW-1:0]] <= wdata;
        end
        rdata_reg <= map_mem[pos_reg[IW-1:0]];
    end

    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        first_next = first_reg;
        pos_next   = pos_reg;
        func_next  = func_reg;
        idx_next   = idx_reg;
        size_next  = size_reg;
        pid_next   = pid_reg;
        base_next  = base_reg;
        e_next     = e_reg;
        eidx_next  = eidx_reg;
        end_next   = end_reg;
        rb_next    = rb_reg;
        lb_next    = lb_reg;
        fs_next    = fs_reg;
        fe_next    = fe_reg;
        ft_next    = ft_reg;
        fv_next    = fv_reg;
        rv_next    = rv_reg;
        st_next    = st_reg;
        raddr_next = raddr_reg;
        clen_next  = clen_reg;
        mv_next    = mv_reg;
        mfrom_next = mfrom_reg;
        mlen_next  = mlen_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        we     = 1'b0;
        wdata  = E_FREE;
        lb_dec = lb_reg;
        do_dec = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                we = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == pos_t'(MAP_ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    idx_next   = s_addr - heap_base_reg;
                    size_next  = s_tdata[26:16];
                    pid_next   = s_tdata[30:27];
                    pos_next   = {1'b0, s_addr - heap_base_reg};
                    ph_next    = 1'b0;
                    first_next = 1'b1;
                    st_next    = ST_OK;
                    raddr_next = '0;
                    clen_next  = '0;
                    mv_next    = 1'b0;
                    mfrom_next = '0;
                    mlen_next  = '0;
                    state_next = S_WALKB;
                end
            end
            S_WALKB: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    first_next = 1'b0;
                    if (first_reg) begin
                        eidx_next = ev;
                    end
                    if (pos_reg != '0 && ev == E_CONT) begin
                        pos_next = pos_reg - 1'b1;
                    end else begin
                        base_next  = pos_reg;
                        e_next     = ev;
                        state_next = S_DISP;
                    end
                end
            end
            S_DISP: begin
                ph_next  = 1'b0;
                pos_next = base_reg + 1'b1;
                case (func_reg)
                    F_CLAIM: begin
                        if (pid_reg == 4'd0 || pid_reg > 4'd8) begin
                            st_next    = ST_NOT_OWNER;
                            state_next = S_DONE;
                        end else if (size_reg == '0 ||
                                     {1'b0, idx_reg} + pos_t'(size_reg) >
                                     pos_t'(MAP_ENTRIES)) begin
                            st_next    = ST_NO_ROOM;
                            state_next = S_DONE;
                        end else begin
                            pos_next   = {1'b0, idx_reg};
                            state_next = S_SCAN;
                        end
                    end
                    F_FREE, F_FORCE: begin
                        if (e_reg == E_FREE || e_reg == E_CONT) begin
                            st_next    = ST_FREE;
                            state_next = S_DONE;
                        end else if (func_reg == F_FREE && e_reg != pid_reg) begin
                            st_next    = ST_NOT_OWNER;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_FWD;
                        end
                    end
                    F_LENGTH: begin
                        if (eidx_reg == E_FREE || e_reg == E_CONT) begin
                            st_next    = ST_FREE;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_FWD;
                        end
                    end
                    F_RESIZE: begin
                        // resize to zero behaves as free on the base entry
                        if ((size_reg == '0 && e_reg == E_FREE) || e_reg == E_CONT ||
                            (size_reg != '0 && eidx_reg == E_FREE)) begin
                            st_next    = ST_FREE;
                            state_next = S_DONE;
                        end else if (e_reg != pid_reg) begin
                            st_next    = ST_NOT_OWNER;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_FWD;
                        end
                    end
                    default: begin
                        // shared open and close: single base entry update
                        fs_next  = base_reg;
                        fe_next  = base_reg + 1'b1;
                        ft_next  = base_reg + 1'b1;
                        rv_next  = E_FREE;
                        fv_next  = e_reg;
                        pos_next = base_reg;
                        raddr_next = heap_base_reg + base_reg[15:0];
                        state_next = S_FILL;
                        if (e_reg <= E_PROC_MAX || e_reg == E_CONT) begin
                            st_next    = ST_NOT_SHRD;
                            raddr_next = '0;
                            state_next = S_DONE;
                        end else if (func_reg == F_RDOPEN) begin
                            if (e_reg == E_WLOCK || e_reg == E_RLOCK5) begin
                                st_next    = ST_BUSY;
                                raddr_next = '0;
                                state_next = S_DONE;
                            end else begin
                                fv_next = (e_reg == E_SHARED) ? E_RLOCK1 : e_reg + 1'b1;
                            end
                        end else if (func_reg == F_WROPEN) begin
                            if (e_reg != E_SHARED) begin
                                st_next    = ST_BUSY;
                                raddr_next = '0;
                                state_next = S_DONE;
                            end else begin
                                fv_next = E_WLOCK;
                            end
                        end else begin
                            if (e_reg == E_WLOCK || e_reg == E_RLOCK1) begin
                                fv_next = E_SHARED;
                            end else if (e_reg > E_RLOCK1) begin
                                fv_next = e_reg - 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_SCAN: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (ev != E_FREE) begin
                        st_next    = ST_NO_ROOM;
                        state_next = S_DONE;
                    end else if (pos_reg + 1'b1 == {1'b0, idx_reg} + pos_t'(size_reg)) begin
                        fs_next    = {1'b0, idx_reg};
                        fe_next    = {1'b0, idx_reg} + pos_t'(size_reg);
                        ft_next    = {1'b0, idx_reg} + pos_t'(size_reg);
                        fv_next    = pid_reg;
                        rv_next    = E_CONT;
                        pos_next   = {1'b0, idx_reg};
                        raddr_next = heap_base_reg + idx_reg;
                        state_next = S_FILL;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            S_FWD: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (ev == E_CONT) begin
                        pos_next = pos_reg + 1'b1;
                    end else begin
                        end_next = pos_reg;
                        raddr_next = heap_base_reg + base_reg[15:0];
                        if (func_reg == F_LENGTH) begin
                            clen_next  = sat_len(pos_reg - base_reg);
                            state_next = S_DONE;
                        end else if (func_reg != F_RESIZE || size_reg == '0) begin
                            if (func_reg == F_RESIZE) begin
                                raddr_next = '0;
                            end
                            fs_next    = base_reg;
                            fe_next    = pos_reg;
                            ft_next    = pos_reg;
                            fv_next    = E_FREE;
                            rv_next    = E_FREE;
                            pos_next   = base_reg;
                            state_next = S_FILL;
                        end else if (bs <= pos_reg) begin
                            // shrink in place
                            fs_next    = bs;
                            fe_next    = pos_reg;
                            ft_next    = pos_reg;
                            fv_next    = E_FREE;
                            rv_next    = E_FREE;
                            pos_next   = bs;
                            state_next = S_FILL;
                        end else begin
                            state_next = S_RWALK;
                        end
                    end
                end
            end
            S_RWALK: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (in_range && ev == E_FREE) begin
                        pos_next = pos_reg + 1'b1;
                    end else begin
                        rb_next = pos_reg;
                        if (bs <= pos_reg) begin
                            // grow to the right
                            fs_next    = end_reg;
                            fe_next    = bs;
                            ft_next    = bs;
                            fv_next    = E_CONT;
                            rv_next    = E_CONT;
                            pos_next   = end_reg;
                            state_next = S_FILL;
                        end else if (base_reg == '0) begin
                            lb_dec = '0;
                            do_dec = 1'b1;
                        end else begin
                            lb_next    = base_reg;
                            pos_next   = base_reg - 1'b1;
                            state_next = S_LWALK;
                        end
                    end
                end
            end
            S_LWALK: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (ev == E_FREE) begin
                        lb_next = pos_reg;
                        if (pos_reg == '0) begin
                            lb_dec = '0;
                            do_dec = 1'b1;
                        end else begin
                            pos_next = pos_reg - 1'b1;
                        end
                    end else begin
                        lb_dec = lb_reg;
                        do_dec = 1'b1;
                    end
                end
            end
            S_FILL: begin
                if (pos_reg < ft_reg) begin
                    we = in_range;
                    wdata = (pos_reg == fs_reg) ? fv_reg :
                            (pos_reg < fe_reg) ? rv_reg : E_FREE;
                    pos_next = pos_reg + 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = st_reg;
                    m_data_next  = {1'b0, mlen_reg, mfrom_reg, mv_reg, clen_reg, raddr_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // move-left decision for the left walk ends and for a chunk at base zero
        if (do_dec) begin
            if (lb_dec + pos_t'(size_reg) <= rb_next) begin
                fs_next    = lb_dec;
                fe_next    = lb_dec + pos_t'(size_reg);
                ft_next    = (lb_dec + pos_t'(size_reg) > end_reg) ?
                             lb_dec + pos_t'(size_reg) : end_reg;
                fv_next    = pid_reg;
                rv_next    = E_CONT;
                pos_next   = lb_dec;
                raddr_next = heap_base_reg + lb_dec[15:0];
                mv_next    = 1'b1;
                mfrom_next = heap_base_reg + base_reg[15:0];
                mlen_next  = sat_len(end_reg - base_reg);
                state_next = S_FILL;
            end else begin
                st_next    = ST_NO_ROOM;
                raddr_next = '0;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            ph_reg        <= 1'b0;
            first_reg     <= 1'b0;
            pos_reg       <= '0;
            heap_base_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            first_reg   <= first_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                heap_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        idx_reg    <= idx_next;
        size_reg   <= size_next;
        pid_reg    <= pid_next;
        base_reg   <= base_next;
        e_reg      <= e_next;
        eidx_reg   <= eidx_next;
        end_reg    <= end_next;
        rb_reg     <= rb_next;
        lb_reg     <= lb_next;
        fs_reg     <= fs_next;
        fe_reg     <= fe_next;
        ft_reg     <= ft_next;
        fv_reg     <= fv_next;
        rv_reg     <= rv_next;
        st_reg     <= st_next;
        raddr_reg  <= raddr_next;
        clen_reg   <= clen_next;
        mv_reg     <= mv_next;
        mfrom_reg  <= mfrom_next;
        mlen_reg   <= mlen_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule
`default_nettype wire

[sv/nam_checker.sv]
// port-level checks for the nibble allocation map engine
// depends on nam_pkg and on the engine top level, which the bind below attaches to
`timescale 1ns / 1ps
`default_nettype none
module nam_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [15:0] cfg_data,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [2:0]  m_tuser
);
    import nam_pkg::*;

    // a waiting result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_FREE)
        else $error("status code out of range");

    // a move report (made only by a successful resize) comes with an OK status and a nonzero move length
    a_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> m_tuser == ST_OK && m_tdata[54:44] != 11'd0)
        else $error("move reported on failed request");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[26:16] != 11'd0 |-> m_tuser == ST_OK && !m_tdata[27])
        else $error("length reported with bad status");

    // the map is being cleared right after reset
    a_rst: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid && !s_tready)
        else $error("block active right after reset");

endmodule

bind nibble_allocation_map_engine nam_checker u_nam_checker (.*);
`default_nettype wire

[sim/nibble_allocation_map_engine_tb.sv]
// self-checking testbench for the nibble allocation map engine: directed and random requests
// are checked against an in-bench model of the allocation map; depends on nam_pkg and the rtl
`timescale 1ns / 1ps
module nibble_allocation_map_engine_tb;
    import nam_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] raddr;
        logic [10:0] clen;
        logic        mv;
        logic [15:0] mfrom;
        logic [10:0] mlen;
    } map_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;

    always #4 aclk = ~aclk;

    nibble_allocation_map_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    logic [3:0]  heap_map [MAP_ENTRIES];
    logic [15:0] heap_base_addr = '0;
    map_result_t pending_results[$];
    logic [15:0] live_chunks[$];
    int          err_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;

    function automatic logic [3:0] map_rd(int i);
        return (i < MAP_ENTRIES) ? heap_map[i] : E_FREE;
    endfunction

    function automatic void map_wr(int i, logic [3:0] v);
        if (i < MAP_ENTRIES)
            heap_map[i] = v;
    endfunction

    function automatic int find_base(int i);
        while (i > 0 && map_rd(i) == E_CONT)
            i--;
        return i;
    endfunction

    function automatic int find_end(int b);
        int i;
        i = b + 1;
        while (i < MAP_ENTRIES && map_rd(i) == E_CONT)
            i++;
        return i;
    endfunction

    function automatic logic [10:0] clip_len(int n);
        return (n > 2047) ? 11'd2047 : n[10:0];
    endfunction

    // applies one request to the heap map and returns the response it should produce
    function automatic map_result_t heap_apply(logic [2:0] fn, logic [15:0] addr,
                                               logic [10:0] size, logic [3:0] pid);
        map_result_t r;
        logic [15:0] d;
        int idx, sz, b, e, rend, rb, lb, i;
        r = '0;
        d = addr - heap_base_addr;
        idx = d;
        sz = size;
        b = find_base(idx);
        e = map_rd(b);
        if (fn == F_CLAIM) begin
            if (pid < 1 || pid > 8) begin
                r.status = ST_NOT_OWNER;
            end else if (sz == 0 || idx + sz > MAP_ENTRIES) begin
                r.status = ST_NO_ROOM;
            end else begin
                for (i = idx; i < idx + sz; i++)
                    if (map_rd(i) != E_FREE) r.status = ST_NO_ROOM;
                if (r.status == ST_OK) begin
                    map_wr(idx, pid);
                    for (i = idx + 1; i < idx + sz; i++) map_wr(i, E_CONT);
                    r.raddr = heap_base_addr + idx[15:0];
                end
            end
        end else if (fn == F_FREE || (fn == F_RESIZE && sz == 0)) begin
            if (e == E_FREE || e == E_CONT) begin
                r.status = ST_FREE;
            end else if (e != pid) begin
                r.status = ST_NOT_OWNER;
            end else begin
                rend = find_end(b);
                for (i = b; i < rend; i++) map_wr(i, E_FREE);
                r.raddr = (fn == F_FREE) ? heap_base_addr + b[15:0] : 16'd0;
            end
        end else if (fn == F_FORCE) begin
            if (e == E_FREE || e == E_CONT) begin
                r.status = ST_FREE;
            end else begin
                rend = find_end(b);
                for (i = b; i < rend; i++) map_wr(i, E_FREE);
                r.raddr = heap_base_addr + b[15:0];
            end
        end else if (fn == F_LENGTH) begin
            if (map_rd(idx) == E_FREE || e == E_CONT) begin
                r.status = ST_FREE;
            end else begin
                r.clen = clip_len(find_end(b) - b);
                r.raddr = heap_base_addr + b[15:0];
            end
        end else if (fn == F_RESIZE) begin
            if (map_rd(idx) == E_FREE || e == E_CONT) begin
                r.status = ST_FREE;
            end else if (e != pid) begin
                r.status = ST_NOT_OWNER;
            end else begin
                rend = find_end(b);
                rb = rend;
                lb = b;
                if (b + sz <= rend) begin
                    for (i = b + sz; i < rend; i++) map_wr(i, E_FREE);
                    r.raddr = heap_base_addr + b[15:0];
                end else begin
                    while (rb < MAP_ENTRIES && map_rd(rb) == E_FREE) rb++;
                    if (b + sz <= rb) begin
                        for (i = rend; i < b + sz; i++) map_wr(i, E_CONT);
                        r.raddr = heap_base_addr + b[15:0];
                    end else begin
                        while (lb > 0 && map_rd(lb - 1) == E_FREE) lb--;
                        if (lb + sz <= rb) begin
                            map_wr(lb, pid);
                            for (i = lb + 1; i < lb + sz; i++) map_wr(i, E_CONT);
                            for (; i < rend; i++) map_wr(i, E_FREE);
                            r.raddr = heap_base_addr + lb[15:0];
                            r.mv = 1'b1;
                            r.mfrom = heap_base_addr + b[15:0];
                            r.mlen = clip_len(rend - b);
                        end else begin
                            r.status = ST_NO_ROOM;
                        end
                    end
                end
            end
        end else begin
            if (e <= E_PROC_MAX || e == E_CONT) begin
                r.status = ST_NOT_SHRD;
            end else if (fn == F_RDOPEN) begin
                if (e == E_WLOCK || e == E_RLOCK5) begin
                    r.status = ST_BUSY;
                end else begin
                    map_wr(b, (e == E_SHARED) ? E_RLOCK1 : 4'(e + 1));
                    r.raddr = heap_base_addr + b[15:0];
                end
            end else if (fn == F_WROPEN) begin
                if (e != E_SHARED) begin
                    r.status = ST_BUSY;
                end else begin
                    map_wr(b, E_WLOCK);
                    r.raddr = heap_base_addr + b[15:0];
                end
            end else begin
                if (e == E_WLOCK || e == E_RLOCK1) map_wr(b, E_SHARED);
                else if (e > E_RLOCK1) map_wr(b, 4'(e - 1));
                r.raddr = heap_base_addr + b[15:0];
            end
        end
        return r;
    endfunction

    // response checker and ready pacing
    always @(posedge aclk) begin
        map_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[15:0], m_tdata[26:16], m_tdata[27],
                   m_tdata[43:28], m_tdata[54:44]};
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected response %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: status %0d/%0d addr %h/%h len %0d/%0d",
                                  " mv %b/%b from %h/%h mlen %0d/%0d"},
                                 want.status, got.status, want.raddr, got.raddr,
                                 want.clen, got.clen, want.mv, got.mv,
                                 want.mfrom, got.mfrom, want.mlen, got.mlen);
                end
            end
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(logic [2:0] fn, logic [15:0] addr, logic [10:0] size,
                                logic [3:0] pid);
        map_result_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {1'b0, pid, size, addr};
        do @(posedge aclk); while (!s_tready);
        r = heap_apply(fn, addr, size, pid);
        pending_results.push_back(r);
        if (fn == F_CLAIM && r.status == ST_OK) begin
            live_chunks.push_back(r.raddr);
            if (live_chunks.size() > 48) void'(live_chunks.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_base(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        heap_base_addr = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [15:0] u;
        u = heap_base_addr;
        send_request(F_CLAIM,  u,            11'd1,    4'd1);
        send_request(F_CLAIM,  u + 16'd1023, 11'd1,    4'd7);
        send_request(F_CLAIM,  u,            11'd1024, 4'd2);
        send_request(F_CLAIM,  u + 16'd10,   11'd4,    4'd0);
        send_request(F_CLAIM,  u + 16'd10,   11'd4,    4'd15);
        send_request(F_CLAIM,  u + 16'd10,   11'd0,    4'd3);
        send_request(F_CLAIM,  u + 16'd100,  11'd4,    4'd2);
        send_request(F_LENGTH, u + 16'd102,  11'd0,    4'd2);
        send_request(F_LENGTH, u + 16'd200,  11'd0,    4'd2);
        send_request(F_FREE,   u + 16'd101,  11'd0,    4'd5);
        send_request(F_RESIZE, u + 16'd100,  11'd3,    4'd2);
        send_request(F_CLAIM,  u + 16'd104,  11'd2,    4'd3);
        send_request(F_RESIZE, u + 16'd100,  11'd4,    4'd2);
        send_request(F_RESIZE, u + 16'd101,  11'd8,    4'd2);
        send_request(F_RESIZE, u + 16'd1,    11'd2047, 4'd2);
        send_request(F_RESIZE, u + 16'd104,  11'd0,    4'd3);
        send_request(F_FORCE,  u + 16'd3,    11'd0,    4'd4);
        send_request(F_FORCE,  u + 16'd500,  11'd0,    4'd4);
        send_request(F_FREE,   u + 16'd1023, 11'd0,    4'd7);
        send_request(F_CLAIM,  u + 16'd300,  11'd16,   4'd8);
        send_request(F_RDOPEN, u + 16'd1,    11'd0,    4'd1);
        repeat (6) send_request(F_RDOPEN, u + 16'd305, 11'd0, 4'd8);
        send_request(F_WROPEN, u + 16'd300,  11'd0,    4'd8);
        repeat (6) send_request(F_CLOSE, u + 16'd300, 11'd0, 4'd8);
        send_request(F_WROPEN, u + 16'd310,  11'd0,    4'd8);
        send_request(F_RDOPEN, u + 16'd300,  11'd0,    4'd8);
        send_request(F_CLOSE,  u + 16'd300,  11'd0,    4'd8);
        send_request(F_LENGTH, u - 16'd1,    11'd0,    4'd8);
        wait_drained();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic [2:0]  fn;
        logic [15:0] addr;
        logic [10:0] size;
        logic [3:0]  pid;
        logic [15:0] d;
        int          pick, b;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            fn = (pick < 30) ? F_CLAIM : 3'($urandom_range(7));
            pick = $urandom_range(99);
            if (fn != F_CLAIM && pick < 75 && live_chunks.size() > 0)
                addr = live_chunks[$urandom_range(live_chunks.size() - 1)]
                       + 16'($urandom_range(3));
            else if (pick < 93)
                addr = heap_base_addr + 16'($urandom_range(1100));
            else
                addr = 16'($urandom);
            pick = $urandom_range(99);
            size = (pick < 80) ? 11'($urandom_range(16, 1)) :
                   (pick < 95) ? 11'($urandom_range(64)) : 11'($urandom_range(2047));
            d = addr - heap_base_addr;
            b = find_base(d);
            pick = $urandom_range(99);
            if (pick < 70 && map_rd(b) >= 1 && map_rd(b) <= E_PROC_MAX)
                pid = map_rd(b);
            else if (pick < 90)
                pid = 4'($urandom_range(8, 1));
            else
                pid = 4'($urandom_range(15));
            if (fn inside {F_RDOPEN, F_WROPEN, F_CLOSE} && pick < 50)
                pid = E_SHARED;
            send_request(fn, addr, size, pid);
            // occasionally let the engine empty before going on
            if (n % 97 == 96) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 600;
        for (int n = 0; n < 30; n++)
            send_request(F_LENGTH, heap_base_addr + 16'($urandom_range(1023)), 11'd0, 4'd1);
        wait_drained();
    endtask

    initial begin
        #(64'd150_000_000);
        $display("nibble_allocation_map_engine_tb: done, errors");
        $finish;
    end

    initial begin
        for (int i = 0; i < MAP_ENTRIES; i++) heap_map[i] = E_FREE;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(300, 0, 0);
        write_base(16'hFFFF);
        test_directed();
        test_random(300, 49, 0);
        write_base(16'h1234);
        test_backpressure();
        test_random(300, 0, 49);
        write_base(16'hFC00);
        test_random(300, 31, 31);
        write_base(16'($urandom));
        test_random(100, 0, 0);
        write_base(16'h0000);
        test_random(50, 31, 31);
        wait (pending_results.size() == 0);
        repeat (50) @(posedge aclk);
        if (err_count == 0)
            $display("nibble_allocation_map_engine_tb: done, clean");
        else
            $display("nibble_allocation_map_engine_tb: done, errors");
        $finish;
    end
endmodule
